// ----- rtl/qse_pkg.sv -----
// Package of shared constants, types and functions for the quadratic spline evaluator.
`timescale 1ns / 1ps
`default_nettype none
package qse_pkg;
    localparam int MAX_SEGMENTS = 64;
    localparam int MAX_DIM      = 8;
    localparam int DIM_W        = $clog2(MAX_DIM);
    localparam int KNOT_COUNT   = 2 * MAX_SEGMENTS + 1;
    localparam int KNOT_W       = $clog2(KNOT_COUNT);
    localparam int STORE_DEPTH  = KNOT_COUNT * MAX_DIM;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int SEG_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int ONE_Q16      = 65536;

    localparam logic [1:0] CFG_START    = 2'd0;
    localparam logic [1:0] CFG_DURATION = 2'd1;
    localparam logic [1:0] CFG_SEGMENTS = 2'd2;
    localparam logic [1:0] CFG_DIM      = 2'd3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_DIV1, ST_DIV2, ST_WMUL, ST_WSUM,
        ST_RD0, ST_RDC, ST_RD1, ST_ACC, ST_OUT
    } state_t;

    // Round a Q.16-scaled product to nearest, ties toward plus infinity.
    function automatic logic signed [47:0] round_q16(input logic signed [63:0] n);
        logic signed [63:0] s;
        s = n + 64'sd32768;
        return s[63:16];
    endfunction
endpackage
`default_nettype wire

// ----- rtl/qse_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module qse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1032
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] addr,
    input  wire [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- rtl/qse_divider.sv -----
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps
`default_nettype none
module qse_divider
    import qse_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         start,
    input  wire  [63:0] dividend,
    input  wire  [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [31:0] remainder
);
    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] div_reg, div_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [32:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = trial[31:0] - div_reg;
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule
`default_nettype wire

// ----- rtl/quadratic_spline_evaluator_top.sv -----
// Top level of the quadratic spline evaluator: knot store, sequencer and result register.
// A knot load gives no result, and the next item can follow at once. An out-of-span
// query shows its result in the cycle after its transaction. An in-span query first divides
// for segment and fraction, then forms the weights, then reads and sums three knots per
// component; at the end time it takes only the last knot and skips the fraction and weights.
// One item at a time; output stalls hold the sequencer. Reset (aresetn, synchronous,
// active low) restores the control state and register defaults, not the knot store.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_spline_evaluator_top
    import qse_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    // tdata, from bit 0: knot_index[7:0], component[2:0], knot_value[31:0],
    // query_time[31:0], zero fill to 80 bits
    input  wire  [79:0] s_tdata,
    // tuser: func
    input  wire         s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // tdata, from bit 0: value[31:0], out_component[2:0], out_of_range, zero fill to 40 bits
    output logic [39:0] m_tdata,
    output logic        m_tlast
);
    // Configuration registers.
    logic [31:0] start_reg, dur_reg;
    logic [6:0]  seg_cnt_reg;
    logic [3:0]  dim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= '0;
            dur_reg     <= 32'd1;
            seg_cnt_reg <= 7'd1;
            dim_reg     <= 4'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_START:    start_reg   <= cfg_wdata;
                CFG_DURATION: dur_reg     <= cfg_wdata;
                CFG_SEGMENTS: seg_cnt_reg <= cfg_wdata[6:0];
                CFG_DIM:      dim_reg     <= cfg_wdata[3:0];
                default:      ;
            endcase
        end
    end

    // Effective register values after the clamping rules.
    logic [31:0] dur_eff;
    logic [SEG_W-1:0] nseg_eff;
    logic [DIM_W:0]   dim_eff;
    always_comb begin
        dur_eff = (dur_reg == '0) ? 32'd1 : dur_reg;
        if (seg_cnt_reg == '0) nseg_eff = SEG_W'(1);
        else if (32'(seg_cnt_reg) > MAX_SEGMENTS) nseg_eff = SEG_W'(MAX_SEGMENTS);
        else nseg_eff = SEG_W'(seg_cnt_reg);
        if (dim_reg == '0) dim_eff = (DIM_W+1)'(1);
        else if (32'(dim_reg) > MAX_DIM) dim_eff = (DIM_W+1)'(MAX_DIM);
        else dim_eff = (DIM_W+1)'(dim_reg);
    end

    // Input fields.
    logic [7:0]  in_kidx;
    logic [2:0]  in_comp;
    logic [31:0] in_kval, in_qt;
    assign in_kidx = s_tdata[7:0];
    assign in_comp = s_tdata[10:8];
    assign in_kval = s_tdata[42:11];
    assign in_qt   = s_tdata[74:43];

    state_t state_reg, state_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic [63:0] scaled_reg, scaled_next;
    logic [SEG_W-1:0] seg_reg, seg_next;
    logic [17:0] tau_reg, tau_next;
    logic signed [18:0] l0_reg, l0_next, l1_reg, l1_next, lc_reg, lc_next;
    logic signed [31:0] x0_reg, x0_next;
    logic signed [63:0] acc_reg, acc_next;
    logic [DIM_W:0] k_reg, k_next;
    logic        div_phase_reg, div_phase_next;
    logic        end_reg, end_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_val_reg, out_val_next;
    logic [2:0]  out_comp_reg, out_comp_next;
    logic        out_last_reg, out_last_next, out_oor_reg, out_oor_next;

    // Knot RAM and divider.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0]       ram_rdata;
    qse_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(in_kval), .rdata(ram_rdata)
    );

    logic        div_start, div_done;
    logic [63:0] div_dividend, div_quo;
    logic [31:0] div_rem;
    qse_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_dividend),
        .divisor(dur_eff), .done(div_done), .quotient(div_quo), .remainder(div_rem)
    );

    logic [KNOT_W+1:0] knot_sel;
    logic signed [50:0] prod;
    logic signed [63:0] acc_full;
    logic signed [47:0] rnd;
    logic signed [18:0] t_s, tm1, t2m1, w_sel;
    logic signed [37:0] p0, p1;
    logic [32:0] span_end;
    logic [SEG_W-1:0] seg_small;

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign seg_small = seg_reg;

    // Weight terms: tau - 1 and 2 tau - 1 in Q2.16, and their products in Q.32.
    assign t_s  = $signed({1'b0, tau_reg});
    assign tm1  = t_s - 19'sd65536;
    assign t2m1 = (t_s <<< 1) - 19'sd65536;
    assign p0   = t2m1 * tm1;
    assign p1   = t_s * t2m1;

    // One weight times one knot per read cycle: L0 with the start knot, Lc with the
    // midpoint and L1 with the end knot.
    assign w_sel = (state_reg == ST_RDC) ? l0_reg : (state_reg == ST_RD1) ? lc_reg : l1_reg;
    assign prod  = w_sel * $signed(ram_rdata);

    always_comb begin
        state_next     = state_reg;
        elapsed_next   = elapsed_reg;
        scaled_next    = scaled_reg;
        seg_next       = seg_reg;
        tau_next       = tau_reg;
        l0_next = l0_reg; l1_next = l1_reg; lc_next = lc_reg;
        x0_next = x0_reg; acc_next = acc_reg;
        k_next         = k_reg;
        div_phase_next = div_phase_reg;
        end_next       = end_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_val_next   = out_val_reg;
        out_comp_next  = out_comp_reg;
        out_last_next  = out_last_reg;
        out_oor_next   = out_oor_reg;
        ram_we         = 1'b0;
        div_start      = 1'b0;
        div_dividend   = scaled_reg;
        knot_sel       = '0;
        acc_full       = '0;
        rnd            = '0;
        span_end       = {1'b0, start_reg} + {1'b0, dur_eff};
        ram_addr       = ADDR_W'(32'(in_kidx) * MAX_DIM + 32'(in_comp));

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_tuser == FUNC_LOAD) begin
                        ram_we = (32'(in_kidx) <= 2 * MAX_SEGMENTS) &&
                                 (32'(in_comp) < MAX_DIM);
                    end else if (in_qt < start_reg || {1'b0, in_qt} > span_end) begin
                        out_valid_next = 1'b1;
                        out_val_next   = '0;
                        out_comp_next  = '0;
                        out_last_next  = 1'b1;
                        out_oor_next   = 1'b1;
                    end else begin
                        elapsed_next = in_qt - start_reg;
                        state_next   = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                scaled_next = 64'(elapsed_reg) * 64'(nseg_eff);
                state_next  = ST_DIV1;
                div_phase_next = 1'b0;
            end
            ST_DIV1: begin
                div_start    = 1'b1;
                div_dividend = scaled_reg;
                state_next   = ST_DIV2;
            end
            ST_DIV2: begin
                if (div_done) begin
                    if (!div_phase_reg) begin
                        seg_next = SEG_W'(div_quo);
                        end_next = div_quo >= 64'(nseg_eff);
                        k_next   = '0;
                        if (div_quo >= 64'(nseg_eff)) begin
                            seg_next   = nseg_eff;
                            state_next = ST_RD0;
                        end else begin
                            div_phase_next = 1'b1;
                            scaled_next    = {16'd0, div_rem, 16'd0};
                            state_next     = ST_DIV1;
                        end
                    end else begin
                        tau_next   = div_quo[17:0];
                        state_next = ST_WMUL;
                    end
                end
            end
            ST_WMUL: begin
                l0_next    = 19'(round_q16(64'(p0)));
                l1_next    = 19'(round_q16(64'(p1)));
                state_next = ST_WSUM;
            end
            ST_WSUM: begin
                lc_next    = 19'sd65536 - l0_reg - l1_reg;
                state_next = ST_RD0;
            end
            ST_RD0: begin
                knot_sel   = (KNOT_W+2)'(2 * 32'(seg_small));
                ram_addr   = ADDR_W'(32'(knot_sel) * MAX_DIM + 32'(k_reg));
                state_next = ST_RDC;
            end
            ST_RDC: begin
                knot_sel   = (KNOT_W+2)'(2 * 32'(seg_small) + 1);
                ram_addr   = ADDR_W'(32'(knot_sel) * MAX_DIM + 32'(k_reg));
                x0_next    = $signed(ram_rdata);
                acc_next   = 64'(prod);
                state_next = end_reg ? ST_OUT : ST_RD1;
            end
            ST_RD1: begin
                knot_sel   = (KNOT_W+2)'(2 * 32'(seg_small) + 2);
                ram_addr   = ADDR_W'(32'(knot_sel) * MAX_DIM + 32'(k_reg));
                acc_next   = acc_reg + 64'(prod);
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_full = acc_reg + 64'(prod);
                rnd = round_q16(acc_full);
                if (rnd > 48'sd2147483647) x0_next = 32'sh7FFFFFFF;
                else if (rnd < -48'sd2147483648) x0_next = 32'sh80000000;
                else x0_next = rnd[31:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_val_next   = x0_reg;
                    out_comp_next  = 3'(k_reg);
                    out_oor_next   = 1'b0;
                    out_last_next  = (k_reg + 1'b1) == dim_eff;
                    k_next         = k_reg + 1'b1;
                    state_next     = ((k_reg + 1'b1) == dim_eff) ? ST_IDLE : ST_RD0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        elapsed_reg <= elapsed_next; scaled_reg <= scaled_next; seg_reg <= seg_next;
        tau_reg <= tau_next; l0_reg <= l0_next; l1_reg <= l1_next; lc_reg <= lc_next;
        x0_reg <= x0_next; acc_reg <= acc_next; k_reg <= k_next;
        div_phase_reg <= div_phase_next; end_reg <= end_next;
        out_val_reg <= out_val_next; out_comp_reg <= out_comp_next;
        out_last_reg <= out_last_next; out_oor_reg <= out_oor_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_oor_reg, out_comp_reg, out_val_reg};
    assign m_tlast  = out_last_reg;
endmodule
`default_nettype wire

// ----- rtl/qse_checker.sv -----
// Port-level checker for the quadratic spline evaluator and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module qse_port_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata,
    input wire        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_oor_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[35] |-> m_tlast && m_tdata[31:0] == 32'd0)
        else $error("out-of-range result malformed");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result waits");
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule
bind quadratic_spline_evaluator_top qse_port_checker u_qse_port_checker (.*);
`default_nettype wire
